// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Shared assertion forms.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/poe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package poe_pkg;
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVER = 2'd1,
        ST_EXT  = 2'd2,
        ST_DUP  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_LOAD, S_DUPRD, S_DUPCMP, S_MAPRD, S_MAPACC, S_EMIT, S_ERR, S_DRAIN
    } state_t;

    typedef struct packed {
        logic [2:0]    code;
        logic [3:0]    width;
        logic [3:0]    height;
        logic [63:0]   map;
        logic [1:0]    status;
        logic          last;
    } result_t;
endpackage
`default_nettype wire

// ===== sv/poe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface poe_cell_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] cell_x;
    logic signed [7:0] cell_y;
    logic              last_cell;
    modport source (output valid, cell_x, cell_y, last_cell, input ready);
    modport sink (input valid, cell_x, cell_y, last_cell, output ready);
endinterface

interface poe_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  orientation_code;
    logic [3:0]  shape_width;
    logic [3:0]  shape_height;
    logic [63:0] cell_map;
    logic [1:0]  status;
    logic        last_result;
    modport source (output valid, orientation_code, shape_width, shape_height, cell_map,
                    status, last_result, input ready);
    modport sink (input valid, orientation_code, shape_width, shape_height, cell_map,
                  status, last_result, output ready);
endinterface
`default_nettype wire

// ===== sv/polyomino_orientation_enumerator_unit.sv =====
// After the last cell of a figure the duplicate check compares every pair of cells
// (none for a single cell), then each of the eight orientations is mapped, the distinct ones
// are kept and sent; an error on loading or in the check gives a single error result instead.
// Throughput: one cell per cycle while loading, but the last cell waits while the output
// register holds a result; results leave one per cycle while the receiver takes them.
// Reset (rst_n low, asynchronous) clears the figure state and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module polyomino_orientation_enumerator_unit
    import poe_pkg::*;
#(
    parameter int MAX_CELLS = 8,
    parameter int GRID_SIDE = 8
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    poe_cell_if.sink     cell_in,
    poe_result_if.source result_out
);
    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = $clog2(MAX_CELLS + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic signed [7:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic over_reg;
    logic [AW-1:0] i_reg, j_reg;
    logic [2:0] code_reg;
    logic [15:0] hold_reg;    // first cell of a duplicate pair
    logic [1:0] status_reg;
    logic [63:0] map_reg;
    logic [63:0] kept_reg [8];
    logic [2:0] kept_code_reg [8];
    logic [3:0] nkept_reg;
    logic [3:0] w_reg, h_reg;
    logic out_valid_reg;
    result_t out_reg;

    // The cell memory: written while loading, read for the duplicate and map walks.
    logic mem_we;
    logic [AW-1:0] mem_raddr;
    logic [15:0] mem_rdata;
    poe_cell_mem #(.DEPTH(MAX_CELLS), .AW(AW)) u_mem (
        .clk(clk), .we(mem_we), .waddr(count_reg[AW-1:0]),
        .wdata({cell_in.cell_y, cell_in.cell_x}), .raddr(mem_raddr), .rdata(mem_rdata)
    );

    wire accept = cell_in.valid && cell_in.ready;
    wire full = (count_reg == CW'(MAX_CELLS));
    assign mem_we = accept && !full;
    assign cell_in.ready = (state_reg == S_LOAD) && !(cell_in.last_cell && out_valid_reg);

    // Bounding box including the cell on this beat.
    logic signed [7:0] nminx, nminy, nmaxx, nmaxy;
    logic [8:0] wd, hd;
    always_comb
    begin
        nminx = (cell_in.cell_x < min_x_reg) ? cell_in.cell_x : min_x_reg;
        nminy = (cell_in.cell_y < min_y_reg) ? cell_in.cell_y : min_y_reg;
        nmaxx = (cell_in.cell_x > max_x_reg) ? cell_in.cell_x : max_x_reg;
        nmaxy = (cell_in.cell_y > max_y_reg) ? cell_in.cell_y : max_y_reg;
        wd = 9'(signed'({nmaxx[7], nmaxx}) - signed'({nminx[7], nminx}) + 9'sd1);
        hd = 9'(signed'({nmaxy[7], nmaxy}) - signed'({nminy[7], nminy}) + 9'sd1);
    end

    // Transformed coordinate of the cell read from memory.
    logic [2:0] px, py, tx, ty;
    logic [2:0] wm1, hm1;
    always_comb
    begin
        px = 3'(mem_rdata[7:0] - min_x_reg);
        py = 3'(mem_rdata[15:8] - min_y_reg);
        wm1 = 3'(w_reg - 4'd1);
        hm1 = 3'(h_reg - 4'd1);
        if (code_reg[0]) px = wm1 - px;
        if (code_reg[1]) py = hm1 - py;
        tx = code_reg[2] ? py : px;
        ty = code_reg[2] ? px : py;
    end

    logic dup_hit;
    always_comb
    begin
        dup_hit = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (4'(k) < nkept_reg && kept_reg[k] == map_reg) dup_hit = 1'b1;
        end
    end

    wire last_i = (CW'(i_reg) == count_reg - CW'(1));
    wire last_j = (CW'(j_reg) == count_reg - CW'(1));
    wire out_free = !out_valid_reg || result_out.ready;
    // The distinct orientations are kept first and sent afterwards, so the final one is known
    // when it is loaded into the output register.
    wire drain_last = ((4'(code_reg) + 4'd1) == nkept_reg);
    wire load_out = out_free && (state_reg == S_ERR || state_reg == S_DRAIN);

    // When the inner loop ends, the next first cell is fetched so that it is ready for the
    // following read cycle.
    always_comb
    begin
        mem_raddr = i_reg;
        if (state_reg == S_DUPRD) mem_raddr = j_reg;
        else if (state_reg == S_DUPCMP && last_j) mem_raddr = i_reg + AW'(1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && cell_in.last_cell)
                begin
                    if (over_reg || full || wd > 9'(GRID_SIDE) || hd > 9'(GRID_SIDE))
                        state_next = S_ERR;
                    else if (count_reg == CW'(0))
                        state_next = S_MAPRD;
                    else
                        state_next = S_DUPRD;
                end
            end
            S_DUPRD: state_next = S_DUPCMP;
            S_DUPCMP:
            begin
                if (mem_rdata == hold_reg) state_next = S_ERR;
                else if (last_j && (CW'(i_reg) + CW'(2) >= count_reg)) state_next = S_MAPRD;
                else state_next = S_DUPRD;
            end
            S_MAPRD: state_next = S_MAPACC;
            S_MAPACC: state_next = last_i ? S_EMIT : S_MAPRD;
            S_EMIT: state_next = (code_reg == 3'd7) ? S_DRAIN : S_MAPRD;
            S_ERR: if (out_free) state_next = S_LOAD;
            S_DRAIN: if (out_free && drain_last) state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            min_x_reg <= 8'sd127;
            min_y_reg <= 8'sd127;
            max_x_reg <= -8'sd128;
            max_y_reg <= -8'sd128;
            over_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            code_reg <= '0;
            nkept_reg <= '0;
            status_reg <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= load_out || (out_valid_reg && !result_out.ready);
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        min_x_reg <= nminx;
                        min_y_reg <= nminy;
                        max_x_reg <= nmaxx;
                        max_y_reg <= nmaxy;
                        if (full) over_reg <= 1'b1;
                        else count_reg <= count_reg + CW'(1);
                        w_reg <= 4'(wd);
                        h_reg <= 4'(hd);
                        i_reg <= '0;
                        j_reg <= AW'(1);
                        code_reg <= '0;
                        nkept_reg <= '0;
                        map_reg <= '0;
                        status_reg <= over_reg || full ? ST_OVER : ST_EXT;
                    end
                end
                S_DUPRD:
                begin
                    if (j_reg == AW'(i_reg + AW'(1))) hold_reg <= mem_rdata;
                end
                S_DUPCMP:
                begin
                    status_reg <= ST_DUP;
                    if (state_next == S_MAPRD)
                    begin
                        i_reg <= '0;
                    end
                    else if (last_j)
                    begin
                        i_reg <= i_reg + AW'(1);
                        j_reg <= AW'(i_reg + AW'(2));
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                S_MAPRD: ;
                S_MAPACC:
                begin
                    map_reg <= map_reg | (64'd1 << {ty, tx});
                    i_reg <= last_i ? '0 : i_reg + AW'(1);
                end
                S_EMIT:
                begin
                    // Only the earliest copy of each cell set is kept.
                    if (!dup_hit)
                    begin
                        kept_reg[nkept_reg[2:0]] <= map_reg;
                        kept_code_reg[nkept_reg[2:0]] <= code_reg;
                        nkept_reg <= nkept_reg + 4'd1;
                    end
                    map_reg <= '0;
                    code_reg <= code_reg + 3'd1;
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{code: 3'd0, width: 4'd0, height: 4'd0, map: 64'd0,
                                     status: status_reg, last: 1'b1};
                        count_reg <= '0; over_reg <= 1'b0;
                        min_x_reg <= 8'sd127; min_y_reg <= 8'sd127;
                        max_x_reg <= -8'sd128; max_y_reg <= -8'sd128;
                    end
                end
                S_DRAIN:
                begin
                    // The orientation counter, wrapped back to zero, walks the kept results.
                    if (out_free)
                    begin
                        out_reg.code <= kept_code_reg[code_reg];
                        out_reg.width <= kept_code_reg[code_reg][2] ? h_reg : w_reg;
                        out_reg.height <= kept_code_reg[code_reg][2] ? w_reg : h_reg;
                        out_reg.map <= kept_reg[code_reg];
                        out_reg.status <= ST_OK;
                        out_reg.last <= drain_last;
                        code_reg <= code_reg + 3'd1;
                        if (drain_last)
                        begin
                            count_reg <= '0;
                            over_reg <= 1'b0;
                            min_x_reg <= 8'sd127;
                            min_y_reg <= 8'sd127;
                            max_x_reg <= -8'sd128;
                            max_y_reg <= -8'sd128;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.orientation_code = out_reg.code;
    assign result_out.shape_width = out_reg.width;
    assign result_out.shape_height = out_reg.height;
    assign result_out.cell_map = out_reg.map;
    assign result_out.status = out_reg.status;
    assign result_out.last_result = out_reg.last;

    `ASSERT_IMPL(a_ready_load, clk, rst_n, cell_in.ready, state_reg == S_LOAD,
        "input ready outside loading")
    `ASSERT_IMPL(a_err_last, clk, rst_n, out_valid_reg && out_reg.status != ST_OK,
        out_reg.last && out_reg.map == 64'd0, "error result malformed")
    `ASSERT_IMPL(a_count, clk, rst_n, 1'b1, count_reg <= CW'(MAX_CELLS),
        "cell count beyond capacity")
endmodule
`default_nettype wire

// ===== sv/poe_cell_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module poe_cell_mem
    import poe_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW = 3
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [15:0]        rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
